### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_ram and text_console_writer.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W = 16;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] RESET_ATTR = 8'd7;

    // Item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [6:0] read_column;
        logic [4:0] read_row;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [15:0] cell_word;
        logic        scrolled;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_BLANK,
        S_OUT
    } t_state;

endpackage

### rtl/core/tcw_ram.sv
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width and the default depth.
module tcw_ram #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/text_console_writer.sv
// Text console writer: character puts and cell reads on a COLUMNS x ROWS screen.
// Depends on tcw_pkg and tcw_ram.
// An accepted item goes to S_OUT, which registers the result once the output is free.
// A scrolling put first blanks the new bottom row in S_BLANK (one write/cycle).
// Reset (sync, active low) clears the cursor and runs a clearing pass over every cell of
// the cell memory; input stalls during the pass and whenever the state is not S_IDLE.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: text attribute register
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_item,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_item  o_out_item
);

    // Geometry. Rows are kept as a ring in memory: r_top is the physical row that
    // shows as logical row 0, so a scroll is a pointer bump plus one row of blanks.
    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ROW_XW = ROW_W + 1;

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_BCOL = ADDR_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ROW_XW-1:0] ROWS_X    = ROW_XW'(ROWS);

    // Logical (row, column) to memory address through the ring offset.
    function automatic logic [ADDR_W-1:0] f_addr(
        input logic [ROW_W-1:0] lrow,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_XW-1:0] sum;
        logic [ROW_W-1:0]  phys;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= ROWS_X) begin
            sum = sum - ROWS_X;
        end
        phys = sum[ROW_W-1:0];
        return ADDR_W'(phys) * COLS_A + ADDR_W'(col);
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tcw_pkg::t_state    r_state, n_state;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;       // clear address / blank column
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ROW_W-1:0]   r_blank_row, n_blank_row;
    logic [7:0]         r_attr;
    logic               r_rd_hit, n_rd_hit;  // result carries memory read data
    logic               r_scr, n_scr;
    logic               r_out_valid, n_out_valid;
    tcw_pkg::t_out_item r_out_item, n_out_item;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic accept;
    logic slot_free;
    logic is_read;
    logic in_range;
    logic scroll;

    assign o_in_stall = (r_state != tcw_pkg::S_IDLE);
    assign accept     = i_in_valid && (r_state == tcw_pkg::S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign is_read    = (i_in_item.kind == tcw_pkg::KIND_READ);
    assign in_range   = ({1'b0, i_in_item.read_column} < 8'(COLUMNS)) &&
                        ({1'b0, i_in_item.read_row} < 6'(ROWS));

    // ---------------------------------------------------------------
    // Memory ports
    // ---------------------------------------------------------------
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    tcw_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                if (r_cnt == LAST_ADDR) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = scroll ? tcw_pkg::S_BLANK : tcw_pkg::S_OUT;
                end
            end
            tcw_pkg::S_BLANK: begin
                if (r_cnt == LAST_BCOL) begin
                    n_state = tcw_pkg::S_OUT;
                end
            end
            tcw_pkg::S_OUT: begin
                if (slot_free) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath: cursor update, memory access, result
    // ---------------------------------------------------------------
    logic             put_we;
    logic [ROW_W-1:0] put_row;
    logic [COL_W-1:0] put_col;
    logic [7:0]       put_char;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_top       = r_top;
        n_blank_row = r_blank_row;
        n_cnt       = r_cnt;
        n_rd_hit    = r_rd_hit;
        n_scr       = r_scr;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        put_we      = 1'b0;
        put_row     = r_row;
        put_col     = r_col;
        put_char    = i_in_item.char_code;
        scroll      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
        mem_re      = 1'b0;
        mem_raddr   = f_addr(i_in_item.read_row[ROW_W-1:0],
                             i_in_item.read_column[COL_W-1:0], r_top);

        // output register drains independently of the work
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // put decode: cursor moves on accept
        if (accept && !is_read) begin
            case (i_in_item.char_code)
                tcw_pkg::CH_BACKSPACE: begin
                    // nothing at the origin
                    if (r_col != '0 || r_row != '0) begin
                        if (r_col == '0) begin
                            n_row = r_row - 1'b1;
                            n_col = LAST_COL;
                        end else begin
                            n_col = r_col - 1'b1;
                        end
                        put_we   = 1'b1;
                        put_row  = n_row;
                        put_col  = n_col;
                        put_char = tcw_pkg::CH_SPACE;
                    end
                end
                tcw_pkg::CH_NEWLINE: begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        scroll = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
                tcw_pkg::CH_TAB: begin
                end
                default: begin
                    put_we = 1'b1;
                    if (r_col == LAST_COL) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            scroll = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            endcase
        end

        case (r_state)
            tcw_pkg::S_CLEAR: begin
                // reset blanks use the reset attribute, not the register
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
                n_cnt     = r_cnt + 1'b1;
            end
            tcw_pkg::S_IDLE: begin
                // the put write uses the ring offset from before any scroll
                mem_we    = put_we;
                mem_waddr = f_addr(put_row, put_col, r_top);
                mem_wdata = {r_attr, put_char};
                mem_re    = accept && is_read && in_range;
                if (accept) begin
                    n_rd_hit = is_read && in_range;
                    n_scr    = scroll;
                    if (scroll) begin
                        // old top row becomes the new bottom row
                        n_blank_row = r_top;
                        n_top       = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                        n_cnt       = '0;
                    end
                end
            end
            tcw_pkg::S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_blank_row) * COLS_A + r_cnt;
                mem_wdata = {r_attr, tcw_pkg::CH_SPACE};
                n_cnt     = r_cnt + 1'b1;
            end
            tcw_pkg::S_OUT: begin
                // read data from the accept-cycle read is valid here
                if (slot_free) begin
                    n_out_valid              = 1'b1;
                    n_out_item.cursor_column = 7'(r_col);
                    n_out_item.cursor_row    = 5'(r_row);
                    n_out_item.cell_word     = r_rd_hit ? mem_rdata : '0;
                    n_out_item.scrolled      = r_scr;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_attr      <= tcw_pkg::RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_blank_row <= n_blank_row;
        r_rd_hit    <= n_rd_hit;
        r_scr       <= n_scr;
        r_out_item  <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
